/* rtl/core/bmm_pkg.sv */
`default_nettype none

package bmm_pkg;

    // Field widths of one bus access and of one result.
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int INDEX_W  = 13;
    localparam int TARGET_W = 3;
    localparam int PAGE_W   = 8;

    // Address of the banking port byte in main RAM.
    localparam logic [ADDR_W-1:0] PORT_ADDR = 16'h0001;

    // Page boundaries of the memory map.
    localparam logic [PAGE_W-1:0] PAGE_BASIC      = 8'ha0;
    localparam logic [PAGE_W-1:0] PAGE_BASIC_LAST = 8'hbf;
    localparam logic [PAGE_W-1:0] PAGE_HIGH_RAM   = 8'hc0;
    localparam logic [PAGE_W-1:0] PAGE_HIGH_LAST  = 8'hcf;
    localparam logic [PAGE_W-1:0] PAGE_IO         = 8'hd0;
    localparam logic [PAGE_W-1:0] PAGE_VIC_LAST   = 8'hd3;
    localparam logic [PAGE_W-1:0] PAGE_SID        = 8'hd4;
    localparam logic [PAGE_W-1:0] PAGE_SID_LAST   = 8'hd7;
    localparam logic [PAGE_W-1:0] PAGE_CIA1       = 8'hdc;
    localparam logic [PAGE_W-1:0] PAGE_CIA2       = 8'hdd;
    localparam logic [PAGE_W-1:0] PAGE_IO_LAST    = 8'hdf;
    localparam logic [PAGE_W-1:0] PAGE_KERNAL     = 8'he0;

    // Register index masks of the devices.
    localparam logic [INDEX_W-1:0] SID_MASK = 13'h001f;
    localparam logic [INDEX_W-1:0] VIC_MASK = 13'h003f;
    localparam logic [INDEX_W-1:0] CIA_MASK = 13'h000f;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_FETCH = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [TARGET_W-1:0] {
        TGT_RAM    = 3'd0,
        TGT_KERNAL = 3'd1,
        TGT_CIA1   = 3'd2,
        TGT_CIA2   = 3'd3,
        TGT_SID    = 3'd4,
        TGT_VIC    = 3'd5,
        TGT_FIXED  = 3'd6
    } target_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // Outcome of decoding one access against the current port byte.
    typedef struct packed {
        target_t              target;
        logic [INDEX_W-1:0]   index;
        logic [DATA_W-1:0]    fixed_data;
        logic                 use_ram;
        logic                 ram_write;
    } decode_t;

endpackage

`default_nettype wire

/* rtl/core/bmm_item_if.sv */
`default_nettype none

interface bmm_item_if import bmm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);

endinterface

`default_nettype wire

/* rtl/core/bmm_result_if.sv */
`default_nettype none

interface bmm_result_if import bmm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] target;
    logic [INDEX_W-1:0]  device_index;
    logic [DATA_W-1:0]   read_data;

    modport source (output valid, output target, output device_index, output read_data,
                    input ready);
    modport sink   (input valid, input target, input device_index, input read_data,
                    output ready);

endinterface

`default_nettype wire

/* rtl/core/banked_memory_map_decoder.sv */
// Banked memory map decoder with a 64K main RAM.
// The req channel takes one bus access (kind, address, write_data); the rsp
// channel returns one transfer per access: target, device_index, read_data.
// Banking follows the RAM byte at address 1, kept in a shadow register that
// every RAM store to that address updates.
// An access is decoded in the cycle it is accepted. RAM stores write the
// single-port RAM in that cycle; RAM reads issue then and their data is
// registered as the access enters the read stage; the result then moves on
// to the output register, which drives rsp.valid, once that register is free.
// Throughput is one access per cycle while rsp.ready stays high, bounded
// by the one RAM port. After reset the RAM is cleared one byte per cycle,
// over all 65536 addresses, during which req.ready stays low. When the
// receiver stalls, the output register holds the result, one further
// access may wait in the read stage, and then req.ready drops until
// rsp.ready returns.
`default_nettype none

module banked_memory_map_decoder import bmm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmm_item_if.sink    req,
    bmm_result_if.source rsp
);

    localparam int RAM_DEPTH = 1 << ADDR_W;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   clear_addr_reg;
    logic [ADDR_W-1:0]   clear_addr_next;
    logic                clear_active;
    logic                clear_last;

    logic [DATA_W-1:0]   port_reg;
    logic [DATA_W-1:0]   port_next;

    decode_t             dec;
    logic                acc;
    logic                out_free;
    logic                stage_adv;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    decode_t             stage_dec_reg;

    logic [DATA_W-1:0]   ram [0:RAM_DEPTH-1];
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   rd_data_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [TARGET_W-1:0] out_target_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [DATA_W-1:0]   out_data_reg;

    // Decode against the port byte as left by all earlier accesses.
    bmm_decode u_decode (
        .kind    (req.kind),
        .address (req.address),
        .port    (port_reg),
        .dec     (dec)
    );

    // Handshake and pipeline advance.
    assign acc       = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign stage_adv = stage_valid_reg && out_free;
    assign req.ready = !clear_active && (!stage_valid_reg || out_free);

    // Next state of the clearing sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the clearing sequencer.
    always_comb
    begin
        clear_active    = 1'b0;
        clear_addr_next = clear_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_active    = 1'b1;
                clear_addr_next = clear_addr_reg + 1'b1;
            end
            ST_RUN:
            begin
                clear_active = 1'b0;
            end
            default:
            begin
                clear_active = 1'b0;
            end
        endcase
    end

    assign clear_last = (clear_addr_reg == {ADDR_W{1'b1}});

    // RAM port: clearing writes, RAM stores, or a read for the accepted access.
    always_comb
    begin
        mem_we    = clear_active || (acc && dec.ram_write);
        mem_re    = acc && dec.use_ram;
        mem_addr  = clear_active ? clear_addr_reg : req.address;
        mem_wdata = clear_active ? '0 : req.write_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ram[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= ram[mem_addr];
    end

    // Shadow of the port byte, kept equal to RAM address 1.
    always_comb
    begin
        port_next = port_reg;
        if (acc && dec.ram_write && req.address == PORT_ADDR)
            port_next = req.write_data;
    end

    // Read stage and output register valid flags.
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (acc)
            stage_valid_next = 1'b1;
        else if (stage_adv)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_adv)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clear_addr_reg  <= '0;
            port_reg        <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_addr_reg  <= clear_addr_next;
            port_reg        <= port_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload of the read stage and of the output register.
    always_ff @(posedge clk)
    begin
        if (acc)
            stage_dec_reg <= dec;
        if (stage_adv)
        begin
            out_target_reg <= stage_dec_reg.target;
            out_index_reg  <= stage_dec_reg.index;
            out_data_reg   <= stage_dec_reg.use_ram ? rd_data_reg
                                                    : stage_dec_reg.fixed_data;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.target       = out_target_reg;
    assign rsp.device_index = out_index_reg;
    assign rsp.read_data    = out_data_reg;

`ifndef SYNTHESIS
    // No access is taken while the RAM is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active |-> !req.ready)
        else $error("access accepted during RAM clear");

    // A RAM store to the port address updates the banking shadow.
    a_port_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && dec.ram_write && req.address == PORT_ADDR)
            |=> (port_reg == $past(req.write_data)))
        else $error("port shadow not updated by store to address 1");

    // An accepted access always occupies the read stage next cycle.
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> stage_valid_reg)
        else $error("accepted access lost before read stage");

    // A stalled read stage blocks further accesses.
    a_stage_block: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !out_free) |-> !req.ready)
        else $error("access accepted while read stage is blocked");

    // The RAM never sees a store and a read in the same cycle.
    a_one_port_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("RAM port used twice in one cycle");
`endif

endmodule

`default_nettype wire

/* rtl/core/bmm_decode.sv */
`default_nettype none

module bmm_decode import bmm_pkg::*; (
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [DATA_W-1:0] port,
    output decode_t                dec
);

    logic [PAGE_W-1:0]  page;
    logic               io_on;
    logic               basic_off;
    logic [INDEX_W-1:0] addr_low;

    assign page      = address[ADDR_W-1:ADDR_W-PAGE_W];
    assign io_on     = port[0] | port[1];
    assign basic_off = port[0] & port[1];
    assign addr_low  = address[INDEX_W-1:0];

    // Map the access onto RAM, the kernal ROM, a device or a fixed value.
    always_comb
    begin
        dec            = '0;
        dec.target     = TGT_RAM;
        case (kind_t'(kind))
            KIND_STORE:
            begin
                if (io_on && (page inside {[PAGE_SID:PAGE_SID_LAST]}))
                begin
                    dec.target = TGT_SID;
                    dec.index  = addr_low & SID_MASK;
                end
                else if (io_on && (page inside {[PAGE_IO:PAGE_VIC_LAST]}))
                begin
                    dec.target = TGT_VIC;
                    dec.index  = addr_low & VIC_MASK;
                end
                else if (io_on && page == PAGE_CIA1)
                begin
                    dec.target = TGT_CIA1;
                    dec.index  = addr_low & CIA_MASK;
                end
                else if (io_on && page == PAGE_CIA2)
                begin
                    dec.target = TGT_CIA2;
                    dec.index  = addr_low & CIA_MASK;
                end
                else
                begin
                    dec.ram_write = 1'b1;
                end
            end
            KIND_LOAD, KIND_FETCH:
            begin
                if (page >= PAGE_KERNAL)
                begin
                    // Kernal area behaves the same for loads and fetches.
                    if (port[1])
                    begin
                        dec.target = TGT_KERNAL;
                        dec.index  = addr_low;
                    end
                    else
                    begin
                        dec.use_ram = 1'b1;
                    end
                end
                else if (kind_t'(kind) == KIND_FETCH || page < PAGE_BASIC)
                begin
                    dec.use_ram = 1'b1;
                end
                else if (page inside {[PAGE_BASIC:PAGE_BASIC_LAST]})
                begin
                    if (basic_off)
                        dec.target = TGT_FIXED;
                    else
                        dec.use_ram = 1'b1;
                end
                else if (page inside {[PAGE_HIGH_RAM:PAGE_HIGH_LAST]})
                begin
                    dec.use_ram = 1'b1;
                end
                else if (io_on)
                begin
                    // IO pages visible.
                    if (page == PAGE_IO)
                    begin
                        dec.target = TGT_FIXED;
                    end
                    else if (page == PAGE_CIA1)
                    begin
                        dec.target = TGT_CIA1;
                        dec.index  = addr_low & CIA_MASK;
                    end
                    else if (page == PAGE_CIA2)
                    begin
                        dec.target = TGT_CIA2;
                        dec.index  = addr_low & CIA_MASK;
                    end
                    else if (page == PAGE_SID)
                    begin
                        dec.target     = TGT_FIXED;
                        dec.fixed_data = port;
                    end
                    else
                    begin
                        dec.use_ram = 1'b1;
                    end
                end
                else if (port[2])
                begin
                    // Character area answers with the port byte.
                    dec.target     = TGT_FIXED;
                    dec.fixed_data = port;
                end
                else
                begin
                    dec.use_ram = 1'b1;
                end
            end
            default:
            begin
                dec.target = TGT_FIXED;
            end
        endcase
    end

endmodule

`default_nettype wire

/* verif/tb_banked_memory_map_decoder.sv */
`default_nettype none

module tb_banked_memory_map_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import bmm_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // One decoded bus access as the block should report it.
    typedef struct {
        target_t             target;
        logic [INDEX_W-1:0]  index;
        logic [DATA_W-1:0]   data;
    } map_result_t;

    // Shadow of main RAM and the banking it implies, with the queue of
    // decode results still owed by the block.
    class bank_map_predictor;
        bit [DATA_W-1:0] shadow_ram [0:65535];
        map_result_t     owed_results[$];
        int              mismatches;

        function map_result_t ram_byte(logic [ADDR_W-1:0] a);
            map_result_t r;
            r.target = TGT_RAM;
            r.index  = '0;
            r.data   = shadow_ram[a];
            return r;
        endfunction

        function map_result_t device(target_t t, logic [INDEX_W-1:0] idx,
                                     logic [DATA_W-1:0] value);
            map_result_t r;
            r.target = t;
            r.index  = idx;
            r.data   = value;
            return r;
        endfunction

        // Loads, and fetches in the kernal pages, see the banked map.
        function map_result_t banked_load(logic [ADDR_W-1:0] a);
            logic [PAGE_W-1:0] page;
            logic [DATA_W-1:0] port;
            page = a[ADDR_W-1 -: PAGE_W];
            port = shadow_ram[PORT_ADDR];
            if (page < PAGE_BASIC || (page >= PAGE_HIGH_RAM && page <= PAGE_HIGH_LAST))
                return ram_byte(a);
            if (page <= PAGE_BASIC_LAST)
            begin
                if (port[0] && port[1])
                    return device(TGT_FIXED, '0, '0);
                return ram_byte(a);
            end
            if (page <= PAGE_IO_LAST)
            begin
                if (port[1:0] != 2'b00)
                begin
                    if (page == PAGE_IO)
                        return device(TGT_FIXED, '0, '0);
                    if (page == PAGE_CIA1)
                        return device(TGT_CIA1, INDEX_W'(a) & CIA_MASK, '0);
                    if (page == PAGE_CIA2)
                        return device(TGT_CIA2, INDEX_W'(a) & CIA_MASK, '0);
                    if (page == PAGE_SID)
                        return device(TGT_FIXED, '0, port);
                    return ram_byte(a);
                end
                if (port[2])
                    return device(TGT_FIXED, '0, port);
                return ram_byte(a);
            end
            if (port[1])
                return device(TGT_KERNAL, INDEX_W'(a - {PAGE_KERNAL, 8'h00}), '0);
            return ram_byte(a);
        endfunction

        function map_result_t decode_access(kind_t k, logic [ADDR_W-1:0] a,
                                            logic [DATA_W-1:0] d);
            logic [PAGE_W-1:0] page;
            logic [DATA_W-1:0] port;
            page = a[ADDR_W-1 -: PAGE_W];
            port = shadow_ram[PORT_ADDR];
            case (k)
                KIND_LOAD:
                    return banked_load(a);
                KIND_STORE:
                begin
                    // With the IO area banked in, device pages swallow the store.
                    if (port[1:0] != 2'b00)
                    begin
                        if (page >= PAGE_SID && page <= PAGE_SID_LAST)
                            return device(TGT_SID, INDEX_W'(a) & SID_MASK, '0);
                        if (page >= PAGE_IO && page <= PAGE_VIC_LAST)
                            return device(TGT_VIC, INDEX_W'(a) & VIC_MASK, '0);
                        if (page == PAGE_CIA1)
                            return device(TGT_CIA1, INDEX_W'(a) & CIA_MASK, '0);
                        if (page == PAGE_CIA2)
                            return device(TGT_CIA2, INDEX_W'(a) & CIA_MASK, '0);
                    end
                    shadow_ram[a] = d;
                    return device(TGT_RAM, '0, '0);
                end
                KIND_FETCH:
                begin
                    if (page < PAGE_KERNAL)
                        return ram_byte(a);
                    return banked_load(a);
                end
                default:
                    return device(TGT_FIXED, '0, '0);
            endcase
        endfunction

        function void note_access(kind_t k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            owed_results.push_back(decode_access(k, a, d));
        endfunction

        function void check_result(logic [TARGET_W-1:0] target,
                                   logic [INDEX_W-1:0] index, logic [DATA_W-1:0] data);
            map_result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with nothing owed: target %0d index 0x%0h data 0x%0h",
                         $time, target, index, data);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (target !== want.target)
            begin
                $display("%0t: target mismatch: expected %0d, actual %0d",
                         $time, want.target, target);
                mismatches++;
            end
            if (index !== want.index)
            begin
                $display("%0t: device_index mismatch: expected 0x%0h, actual 0x%0h",
                         $time, want.index, index);
                mismatches++;
            end
            if (data !== want.data)
            begin
                $display("%0t: read_data mismatch: expected 0x%0h, actual 0x%0h",
                         $time, want.data, data);
                mismatches++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic hold_off_req = 1'b0;

    bank_map_predictor ledger = new();

    bmm_item_if   req ();
    bmm_result_if rsp ();

    banked_memory_map_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one access and wait for its transfer; valid stays high after it.
    task automatic send_access(kind_t k, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        req.valid      <= 1'b1;
        req.kind       <= k;
        req.address    <= a;
        req.write_data <= d;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        ledger.note_access(k, a, d);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            req.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (ledger.owed() != 0)
            @(posedge clk);
    endtask

    // Random access, biased towards the port byte, a small set of
    // reused addresses and the banked upper pages.
    function automatic void pick_access(output kind_t k, output logic [ADDR_W-1:0] a,
                                        output logic [DATA_W-1:0] d);
        int                roll;
        logic [PAGE_W-1:0] page;
        logic [7:0]        offset;
        d    = DATA_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            k = KIND_LOAD;
        else if (roll < 75)
            k = KIND_STORE;
        else if (roll < 97)
            k = KIND_FETCH;
        else
            k = KIND_NONE;
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            k = KIND_STORE;
            a = PORT_ADDR;
        end
        else if (roll < 45)
        begin
            case ($urandom_range(0, 11))
                0:       page = 8'h00;
                1:       page = 8'h02;
                2:       page = PAGE_BASIC;
                3:       page = PAGE_BASIC_LAST;
                4:       page = PAGE_HIGH_RAM;
                5:       page = PAGE_IO;
                6:       page = PAGE_SID;
                7:       page = 8'hd8;
                8:       page = PAGE_CIA1;
                9:       page = PAGE_CIA2;
                10:      page = PAGE_KERNAL;
                default: page = 8'hff;
            endcase
            if ($urandom_range(0, 3) == 0)
                offset = 8'($urandom);
            else
                offset = 8'($urandom_range(0, 3));
            a = {page, offset};
        end
        else if (roll < 70)
            a = {PAGE_BASIC + 8'($urandom_range(0, 95)), 8'($urandom)};
        else
            a = ADDR_W'($urandom);
    endfunction

    task automatic run_random(int n_items, bit gaps);
        int                left;
        int                burst;
        kind_t             k;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        left = n_items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                pick_access(k, a, d);
                send_access(k, a, d);
            end
            left -= burst;
            if (gaps && $urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end
        idle_sender(1);
    endtask

    // Stimulus: reset, directed accesses, then random phases.
    initial
    begin
        req.valid      = 1'b0;
        req.kind       = KIND_NONE;
        req.address    = '0;
        req.write_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Port byte is zero after reset: everything reads RAM.
        send_access(KIND_LOAD,  16'hffff, 8'h00);
        send_access(KIND_FETCH, 16'h0000, 8'hff);
        // All banking bits set.
        send_access(KIND_STORE, PORT_ADDR, 8'h07);
        send_access(KIND_LOAD,  PORT_ADDR, 8'h00);
        send_access(KIND_LOAD,  16'ha000, 8'h00);
        send_access(KIND_LOAD,  16'hc0ff, 8'h00);
        send_access(KIND_LOAD,  16'hd000, 8'h00);
        send_access(KIND_LOAD,  16'hd4aa, 8'h00);
        send_access(KIND_LOAD,  16'hdc05, 8'h00);
        send_access(KIND_LOAD,  16'hddff, 8'h00);
        send_access(KIND_LOAD,  16'hd800, 8'h00);
        send_access(KIND_LOAD,  16'hffff, 8'h00);
        send_access(KIND_FETCH, 16'he000, 8'h00);
        send_access(KIND_FETCH, 16'hd000, 8'h00);
        send_access(KIND_STORE, 16'hd0ff, 8'hff);
        send_access(KIND_STORE, 16'hd7ff, 8'hff);
        send_access(KIND_STORE, 16'hdc3f, 8'h55);
        send_access(KIND_STORE, 16'hddf0, 8'haa);
        send_access(KIND_STORE, 16'hd800, 8'hff);
        send_access(KIND_LOAD,  16'hd800, 8'h00);
        send_access(KIND_NONE,  16'hffff, 8'hff);
        // Character area only.
        send_access(KIND_STORE, PORT_ADDR, 8'h04);
        send_access(KIND_LOAD,  16'hd123, 8'h00);
        send_access(KIND_STORE, 16'hd400, 8'h5a);
        // IO banked in without the kernal.
        send_access(KIND_STORE, PORT_ADDR, 8'h01);
        send_access(KIND_LOAD,  16'ha000, 8'h00);
        send_access(KIND_LOAD,  16'he000, 8'h00);
        send_access(KIND_LOAD,  16'hd400, 8'h00);
        idle_sender(1);

        run_random(600, 1'b1);

        // Receiver holds off while the sender keeps offering transfers.
        hold_off_req <= 1'b1;
        run_random(80, 1'b0);

        // Sender pauses until every owed result has come back.
        wait_drained();
        run_random(400, 1'b0);
        run_random(800, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: changing stall patterns, plus one long hold-off on request.
    initial
    begin
        int mode;
        int mode_left;
        bit hold_off_done;
        mode          = 0;
        mode_left     = 0;
        hold_off_done = 1'b0;
        rsp.ready     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                rsp.ready    <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= 1'($urandom_range(0, 1));
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Every result transfer is checked against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            ledger.check_result(rsp.target, rsp.device_index, rsp.read_data);
    end

    // Run limit; covers the RAM clearing pass after reset with a wide margin.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
